// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset
`define MCC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included
`define MCC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define MCC_ASSERT(lbl, clk, rst_n, prop)
`define MCC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/mcc_pkg.sv =====
// ---------------------------------------------------------------------------
// mcc_pkg
// Sizes, codes and shared types of the multichannel convolution block.
// ---------------------------------------------------------------------------
package mcc_pkg;

  localparam int KERNEL_SIDE   = 3;
  localparam int KERNEL_COUNT  = 16;
  localparam int CHANNEL_COUNT = 4;
  localparam int IMAGE_SIDE    = 32;
  localparam int OUT_SIDE      = 32;

  // fixed field widths
  localparam int REQ_W  = 2;
  localparam int KERN_W = 4;
  localparam int CHAN_W = 2;
  localparam int POS_W  = 5;
  localparam int TAP_W  = 2;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int RES_W  = 48;

  // taps used per direction: 0..2p (an even side drops its last row/column)
  localparam int TAP_PAD = (KERNEL_SIDE - 1) / 2;
  localparam int TAPS    = 2 * TAP_PAD + 1;
  localparam int STEPS   = CHANNEL_COUNT * TAPS * TAPS;

  localparam int WDEPTH  = KERNEL_COUNT * KERNEL_SIDE * KERNEL_SIDE;
  localparam int IDEPTH  = CHANNEL_COUNT * IMAGE_SIDE * IMAGE_SIDE;
  localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int IADDR_W = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

  localparam int TCNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CCNT_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int CRD_W  = $clog2(IMAGE_SIDE);
  localparam int MAXW_A = (POS_W > CRD_W) ? POS_W : CRD_W;
  localparam int MAXW   = (MAXW_A > TCNT_W) ? MAXW_A : TCNT_W;
  localparam int SUM_W  = MAXW + 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_WEIGHT  = 2'd0,
    REQ_PIXEL   = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic                     we_w;
    logic                     we_i;
    logic [WADDR_W-1:0]       waddr;
    logic [IADDR_W-1:0]       iaddr;
    logic signed [VAL_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic               en;
    logic               last;
    logic [WADDR_W-1:0] waddr;
    logic [IADDR_W-1:0] iaddr;
  } mem_rd_t;

  typedef struct packed {
    logic [KERN_W-1:0] kern;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } res_tag_t;

  // replicate border: clamp a sample coordinate into the image
  function automatic logic [CRD_W-1:0] clamp_coord(input logic signed [SUM_W-1:0] c);
    logic [CRD_W-1:0] r;
    if (c[SUM_W-1]) begin
      r = '0;
    end else if (c >= SUM_W'(IMAGE_SIDE)) begin
      r = CRD_W'(IMAGE_SIDE - 1);
    end else begin
      r = c[CRD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/multichannel_conv2d_replicate_border.sv =====
// Weight and pixel writes are taken while idle.
// A compute steps through every channel and tap of its kernel:
// one tap per cycle through the single multiply-accumulate, then the read,
// product and accumulate stages drain; the result then waits in S_PUSH until
// the output register is free. in_ready is low during a compute.
// Reset clears control only; both stores hold garbage until written.
`include "assert_macros.svh"

// ---------------------------------------------------------------------------
// multichannel_conv2d_replicate_border
// Multichannel 3x3 convolution, replicate border, exact 48-bit sum.
// ---------------------------------------------------------------------------
module multichannel_conv2d_replicate_border (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mcc_pkg::REQ_W-1:0]        in_req_type,
  input  logic [mcc_pkg::KERN_W-1:0]       in_kernel_index,
  input  logic [mcc_pkg::CHAN_W-1:0]       in_channel_index,
  input  logic [mcc_pkg::POS_W-1:0]        in_row,
  input  logic [mcc_pkg::POS_W-1:0]        in_col,
  input  logic [mcc_pkg::TAP_W-1:0]        in_tap_row,
  input  logic [mcc_pkg::TAP_W-1:0]        in_tap_col,
  input  logic signed [mcc_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mcc_pkg::KERN_W-1:0]       out_kernel,
  output logic [mcc_pkg::POS_W-1:0]        out_row,
  output logic [mcc_pkg::POS_W-1:0]        out_col,
  output logic signed [mcc_pkg::RES_W-1:0] out_result_value
);
  import mcc_pkg::*;

  mem_wr_t                 wr;
  mem_rd_t                 rd;
  res_tag_t                tag;
  logic                    clear;
  logic                    push;
  logic                    out_free;
  logic signed [VAL_W-1:0] w_data;
  logic signed [VAL_W-1:0] p_data;
  logic                    data_vld;
  logic                    data_last;
  logic signed [RES_W-1:0] acc;
  logic                    mac_done;

  logic                    out_valid_r, out_valid_nxt;
  res_tag_t                out_tag_r;
  logic signed [RES_W-1:0] out_value_r;

  mcc_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_kernel_index  (in_kernel_index),
    .in_channel_index (in_channel_index),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_tap_row       (in_tap_row),
    .in_tap_col       (in_tap_col),
    .in_value         (in_value),
    .mac_done         (mac_done),
    .out_free         (out_free),
    .wr               (wr),
    .rd               (rd),
    .clear            (clear),
    .push             (push),
    .tag              (tag)
  );

  mcc_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .rd        (rd),
    .w_data    (w_data),
    .p_data    (p_data),
    .data_vld  (data_vld),
    .data_last (data_last)
  );

  mcc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (clear),
    .w_data    (w_data),
    .p_data    (p_data),
    .data_vld  (data_vld),
    .data_last (data_last),
    .acc       (acc),
    .done      (mac_done)
  );

  // output register: a finished sum waits here for the consumer
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_tag_r   <= tag;
      out_value_r <= acc;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kernel       = out_tag_r.kern;
  assign out_row          = out_tag_r.row;
  assign out_col          = out_tag_r.col;
  assign out_result_value = out_value_r;

  `MCC_ASSERT(a_no_accept_while_reading, clk, rst_n, rd.en |-> !in_ready)
  `MCC_ASSERT(a_write_not_during_read, clk, rst_n, (wr.we_w || wr.we_i) |-> !rd.en)
  `MCC_ASSERT(a_done_after_issue, clk, rst_n, mac_done |-> (!rd.en && !data_vld))
  `MCC_ASSERT(a_push_into_free_slot, clk, rst_n, push |-> out_free)

endmodule

// ===== hw/rtl/mcc_mem.sv =====
// ---------------------------------------------------------------------------
// mcc_mem
// Weight and image stores, one write and one registered read port each.
// ---------------------------------------------------------------------------
module mcc_mem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcc_pkg::mem_wr_t                wr,
  input  mcc_pkg::mem_rd_t                rd,
  output logic signed [mcc_pkg::VAL_W-1:0] w_data,
  output logic signed [mcc_pkg::VAL_W-1:0] p_data,
  output logic                            data_vld,
  output logic                            data_last
);
  import mcc_pkg::*;

  logic signed [VAL_W-1:0] weight_mem [WDEPTH];
  logic signed [VAL_W-1:0] image_mem  [IDEPTH];

  logic signed [VAL_W-1:0] w_data_r;
  logic signed [VAL_W-1:0] p_data_r;
  logic                    vld_r;
  logic                    last_r;

  always_ff @(posedge clk) begin
    if (wr.we_w) begin
      weight_mem[wr.waddr] <= wr.data;
    end
    w_data_r <= weight_mem[rd.waddr];
  end

  always_ff @(posedge clk) begin
    if (wr.we_i) begin
      image_mem[wr.iaddr] <= wr.data;
    end
    p_data_r <= image_mem[rd.iaddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      last_r <= 1'b0;
    end else begin
      vld_r  <= rd.en;
      last_r <= rd.en & rd.last;
    end
  end

  assign w_data    = w_data_r;
  assign p_data    = p_data_r;
  assign data_vld  = vld_r;
  assign data_last = last_r;

endmodule

// ===== hw/rtl/mcc_mac.sv =====
// ---------------------------------------------------------------------------
// mcc_mac
// Shared multiply-accumulate: registered product, 48-bit exact accumulator.
// ---------------------------------------------------------------------------
module mcc_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clear,
  input  logic signed [mcc_pkg::VAL_W-1:0] w_data,
  input  logic signed [mcc_pkg::VAL_W-1:0] p_data,
  input  logic                             data_vld,
  input  logic                             data_last,
  output logic signed [mcc_pkg::RES_W-1:0] acc,
  output logic                             done
);
  import mcc_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic                     prod_last_r;
  logic signed [RES_W-1:0]  acc_r;
  logic signed [RES_W-1:0]  acc_nxt;
  logic                     done_r;

  always_comb begin
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + RES_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(w_data) * PROD_W'(p_data);
    acc_r  <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r  <= 1'b0;
      prod_last_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      prod_vld_r  <= data_vld;
      prod_last_r <= data_last;
      done_r      <= prod_vld_r & prod_last_r;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

// ===== hw/rtl/mcc_seq.sv =====
// ---------------------------------------------------------------------------
// mcc_seq
// Request decode and tap sequencer: channel, tap row, tap column counters.
// ---------------------------------------------------------------------------
module mcc_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mcc_pkg::REQ_W-1:0]        in_req_type,
  input  logic [mcc_pkg::KERN_W-1:0]       in_kernel_index,
  input  logic [mcc_pkg::CHAN_W-1:0]       in_channel_index,
  input  logic [mcc_pkg::POS_W-1:0]        in_row,
  input  logic [mcc_pkg::POS_W-1:0]        in_col,
  input  logic [mcc_pkg::TAP_W-1:0]        in_tap_row,
  input  logic [mcc_pkg::TAP_W-1:0]        in_tap_col,
  input  logic signed [mcc_pkg::VAL_W-1:0] in_value,
  input  logic                             mac_done,
  input  logic                             out_free,
  output mcc_pkg::mem_wr_t                 wr,
  output mcc_pkg::mem_rd_t                 rd,
  output logic                             clear,
  output logic                             push,
  output mcc_pkg::res_tag_t                tag
);
  import mcc_pkg::*;

  state_t              state_r, state_nxt;
  logic [CCNT_W-1:0]   ch_r, ch_nxt;
  logic [TCNT_W-1:0]   ty_r, ty_nxt;
  logic [TCNT_W-1:0]   tx_r, tx_nxt;
  res_tag_t            tag_r, tag_nxt;

  logic signed [SUM_W-1:0] ys_s;
  logic signed [SUM_W-1:0] xs_s;
  logic [CRD_W-1:0]        ys_c;
  logic [CRD_W-1:0]        xs_c;
  logic                    last_step;

  // sample coordinates of the current tap, clamped to the image
  always_comb begin
    ys_s = SUM_W'(tag_r.row) + SUM_W'(ty_r) - SUM_W'(TAP_PAD);
    xs_s = SUM_W'(tag_r.col) + SUM_W'(tx_r) - SUM_W'(TAP_PAD);
    ys_c = clamp_coord(ys_s);
    xs_c = clamp_coord(xs_s);
  end

  assign last_step = (32'(ch_r) == CHANNEL_COUNT - 1) && (32'(ty_r) == TAPS - 1) &&
                     (32'(tx_r) == TAPS - 1);

  always_comb begin
    rd.en    = (state_r == S_RUN);
    rd.last  = last_step;
    rd.waddr = WADDR_W'((32'(tag_r.kern) * KERNEL_SIDE + 32'(ty_r)) * KERNEL_SIDE +
                        32'(tx_r));
    rd.iaddr = IADDR_W'((32'(ch_r) * IMAGE_SIDE + 32'(ys_c)) * IMAGE_SIDE + 32'(xs_c));
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    ty_nxt    = ty_r;
    tx_nxt    = tx_r;
    tag_nxt   = tag_r;
    in_ready  = 1'b0;
    clear     = 1'b0;
    push      = 1'b0;
    wr.we_w   = 1'b0;
    wr.we_i   = 1'b0;
    wr.data   = in_value;
    wr.waddr  = WADDR_W'((32'(in_kernel_index) * KERNEL_SIDE + 32'(in_tap_row)) *
                         KERNEL_SIDE + 32'(in_tap_col));
    wr.iaddr  = IADDR_W'((32'(in_channel_index) * IMAGE_SIDE + 32'(in_row)) *
                         IMAGE_SIDE + 32'(in_col));
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_req_type)
            REQ_WEIGHT: begin
              wr.we_w = (32'(in_kernel_index) < KERNEL_COUNT) &&
                        (32'(in_tap_row) < KERNEL_SIDE) && (32'(in_tap_col) < KERNEL_SIDE);
            end
            REQ_PIXEL: begin
              wr.we_i = (32'(in_channel_index) < CHANNEL_COUNT) &&
                        (32'(in_row) < IMAGE_SIDE) && (32'(in_col) < IMAGE_SIDE);
            end
            REQ_COMPUTE: begin
              // out-of-range compute is taken and dropped
              if ((32'(in_kernel_index) < KERNEL_COUNT) && (32'(in_row) < OUT_SIDE) &&
                  (32'(in_col) < OUT_SIDE)) begin
                tag_nxt.kern = in_kernel_index;
                tag_nxt.row  = in_row;
                tag_nxt.col  = in_col;
                ch_nxt       = '0;
                ty_nxt       = '0;
                tx_nxt       = '0;
                clear        = 1'b1;
                state_nxt    = S_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (32'(tx_r) == TAPS - 1) begin
          tx_nxt = '0;
          if (32'(ty_r) == TAPS - 1) begin
            ty_nxt = '0;
            ch_nxt = ch_r + CCNT_W'(1);
          end else begin
            ty_nxt = ty_r + TCNT_W'(1);
          end
        end else begin
          tx_nxt = tx_r + TCNT_W'(1);
        end
        if (last_step) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (mac_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r  <= ch_nxt;
    ty_r  <= ty_nxt;
    tx_r  <= tx_nxt;
    tag_r <= tag_nxt;
  end

  assign tag = tag_r;

endmodule
